>>> rtl/core/sha256_stream_hasher_defines.svh
// assertion macros for the sha-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/sha256sh_pkg.sv
// types, constants and round functions of the sha-256 stream hasher
package sha256sh_pkg;

  localparam int WordW  = 32;
  localparam int NWords = 8;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [2:0]       word_index;
    logic             digest_last;
  } out_item_t;

  localparam logic [WordW-1:0] H_INIT [NWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/sha256_stream_hasher.sv
// sha-256 stream hasher top level: byte packing, padding, round unit, digest output
//
//   channel | direction | payload                                   | handshake
//   --------+-----------+-------------------------------------------+-------------------
//   in_     | in        | message_byte, has_byte, last              | in_valid/in_ready
//   out_    | out       | digest_word, word_index, digest_last      | out_valid/out_ready
//   cfg_    | in        | double_hash                               | cfg_valid/cfg_ready
//
// one byte per cycle while no block is in flight; the 64th byte of a block starts
// the rounds of the single round unit and then the fold into the chaining words
// a last transaction adds the padding bytes (up to 72) and the compressions,
// double mode adds a load step, 32 padding bytes and one more compression
// the eight digest words leave one per accepted cycle; in_ready is low meanwhile
// reset is synchronous and active low, no clearing pass; cfg_ready is always high
module sha256_stream_hasher (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sha256sh_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256sh_pkg::out_item_t out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_double_hash
);
  import sha256sh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_ROUND  = 6'b000100,
    S_FOLD   = 6'b001000,
    S_REHASH = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bitlen_r, bitlen_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  chain_r [NWords];
  logic [31:0]  chain_nxt [NWords];
  logic [31:0]  wk_r [NWords];
  logic [31:0]  wk_nxt [NWords];
  logic [5:0]   rnd_r, rnd_nxt;
  logic         pend_r, pend_nxt;
  logic         pad_r, pad_nxt;
  logic         mark_r, mark_nxt;
  logic         extra_r, extra_nxt;
  logic         second_r, second_nxt;
  logic         dbl_r, dbl_nxt;
  logic [2:0]   oidx_r, oidx_nxt;

  logic         in_fire, out_fire;
  logic         shift_byte;
  logic [7:0]   byte_val, pad_byte;
  logic [31:0]  win0, win1, win9, win14, w_new, t1, t2;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // schedule taps: oldest word at the top of the window
  assign win0  = blk_r[511:480];
  assign win1  = blk_r[479:448];
  assign win9  = blk_r[223:192];
  assign win14 = blk_r[63:32];

  assign w_new = (rnd_r[5:4] == 2'b00) ? win0
               : win0 + ssig0(win1) + win9 + ssig1(win14);
  assign t1 = wk_r[7] + bsig1(wk_r[4]) + ch_f(wk_r[4], wk_r[5], wk_r[6])
            + k_const(rnd_r) + w_new;
  assign t2 = bsig0(wk_r[0]) + maj_f(wk_r[0], wk_r[1], wk_r[2]);

  always_comb begin
    if (!mark_r) begin
      pad_byte = 8'h80;
    end else if ((fill_r < 6'd56) || extra_r) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bitlen_r[{~fill_r[2:0], 3'b000} +: 8];
    end
  end

  assign out_item  = '{digest_word: chain_r[oidx_r], word_index: oidx_r,
                       digest_last: (oidx_r == 3'd7)};
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    blk_nxt    = blk_r;
    chain_nxt  = chain_r;
    wk_nxt     = wk_r;
    rnd_nxt    = rnd_r;
    pend_nxt   = pend_r;
    pad_nxt    = pad_r;
    mark_nxt   = mark_r;
    extra_nxt  = extra_r;
    second_nxt = second_r;
    dbl_nxt    = dbl_r;
    oidx_nxt   = oidx_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    shift_byte = 1'b0;
    byte_val   = in_item.message_byte;

    if (cfg_valid) begin
      dbl_nxt = cfg_double_hash;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_item.has_byte) begin
            shift_byte = 1'b1;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_item.has_byte && (fill_r == 6'd63)) begin
            state_nxt = S_ROUND;
            pend_nxt  = in_item.last;
          end else if (in_item.last) begin
            state_nxt = S_PAD;
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            extra_nxt = 1'b0;
          end
        end
      end
      S_PAD: begin
        shift_byte = 1'b1;
        byte_val   = pad_byte;
        if (!mark_r) begin
          mark_nxt  = 1'b1;
          extra_nxt = (fill_r >= 6'd56);
        end
        if (fill_r == 6'd63) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        blk_nxt   = {blk_r[479:0], w_new};
        wk_nxt[7] = wk_r[6];
        wk_nxt[6] = wk_r[5];
        wk_nxt[5] = wk_r[4];
        wk_nxt[4] = wk_r[3] + t1;
        wk_nxt[3] = wk_r[2];
        wk_nxt[2] = wk_r[1];
        wk_nxt[1] = wk_r[0];
        wk_nxt[0] = t1 + t2;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        for (int j = 0; j < NWords; j++) begin
          chain_nxt[j] = chain_r[j] + wk_r[j];
        end
        if (pad_r) begin
          if (extra_r) begin
            extra_nxt = 1'b0;
            state_nxt = S_PAD;
          end else if (dbl_r && !second_r) begin
            state_nxt = S_REHASH;
          end else begin
            oidx_nxt  = 3'd0;
            state_nxt = S_OUT;
          end
        end else if (pend_r) begin
          pend_nxt  = 1'b0;
          pad_nxt   = 1'b1;
          mark_nxt  = 1'b0;
          extra_nxt = 1'b0;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REHASH: begin
        blk_nxt[255:0] = {chain_r[0], chain_r[1], chain_r[2], chain_r[3],
                          chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
        fill_nxt   = 6'd32;
        chain_nxt  = H_INIT;
        bitlen_nxt = 64'd256;
        second_nxt = 1'b1;
        mark_nxt   = 1'b0;
        extra_nxt  = 1'b0;
        state_nxt  = S_PAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            chain_nxt  = H_INIT;
            fill_nxt   = 6'd0;
            bitlen_nxt = 64'd0;
            second_nxt = 1'b0;
            pad_nxt    = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // byte path into the block, block full starts the rounds
    if (shift_byte) begin
      blk_nxt  = {blk_r[503:0], byte_val};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        wk_nxt  = chain_r;
        rnd_nxt = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 6'd0;
      bitlen_r <= 64'd0;
      chain_r  <= H_INIT;
      rnd_r    <= 6'd0;
      pend_r   <= 1'b0;
      pad_r    <= 1'b0;
      mark_r   <= 1'b0;
      extra_r  <= 1'b0;
      second_r <= 1'b0;
      dbl_r    <= 1'b0;
      oidx_r   <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      chain_r  <= chain_nxt;
      rnd_r    <= rnd_nxt;
      pend_r   <= pend_nxt;
      pad_r    <= pad_nxt;
      mark_r   <= mark_nxt;
      extra_r  <= extra_nxt;
      second_r <= second_nxt;
      dbl_r    <= dbl_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    wk_r  <= wk_nxt;
  end

endmodule

>>> rtl/core/sha256sh_checker.sv
// port-level checker for the sha-256 stream hasher and its bind
`include "sha256_stream_hasher_defines.svh"

module sha256sh_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input sha256sh_pkg::out_item_t out_item
);
  import sha256sh_pkg::*;

  // stalled result transaction holds
  `SHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_item))
  // no input taken while a digest is being delivered
  `SHS_ASSERT_NOW(a_no_in_during_out, out_valid, !in_ready)
  // final flag sits on word seven only
  `SHS_ASSERT_NOW(a_last_word, out_valid,
                  out_item.digest_last == (out_item.word_index == 3'd7))
  // words follow one another without a gap
  `SHS_ASSERT_NEXT(a_word_step, out_valid && out_ready && !out_item.digest_last,
                   out_valid && (out_item.word_index == $past(out_item.word_index) + 3'd1))
  // digest ends after its final word
  `SHS_ASSERT_NEXT(a_digest_end, out_valid && out_ready && out_item.digest_last,
                   !out_valid)

endmodule

bind sha256_stream_hasher sha256sh_checker u_sha256sh_checker (.*);
